FILE: design/obl_pkg.sv
// Shared constants, request and result types of the order book level table.
package obl_pkg;

  localparam int NUM_LEVELS = 65536;
  localparam int WALK_STEP  = 1;
  localparam int QTY_BITS   = 48;

  localparam int ADDR_W     = $clog2(NUM_LEVELS);
  localparam int BA_W       = ADDR_W + 1;

  localparam int LEVEL_W    = 16;
  localparam int BEST_ASK_W = 17;
  localparam int QTY_W      = 48;
  localparam int LSIDE_W    = 2;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

  localparam logic [LSIDE_W-1:0] LSIDE_NONE = 2'd0;
  localparam logic [LSIDE_W-1:0] LSIDE_ASK  = 2'd1;
  localparam logic [LSIDE_W-1:0] LSIDE_BID  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic               side;
    logic [LEVEL_W-1:0] tick_level;
    logic [QTY_W-1:0]   quantity;
  } obl_in_t;

  typedef struct packed {
    logic [BEST_ASK_W-1:0] best_ask_level;
    logic [QTY_W-1:0]      best_ask_quantity;
    logic [LEVEL_W-1:0]    best_bid_level;
    logic [QTY_W-1:0]      best_bid_quantity;
    logic [QTY_W-1:0]      level_quantity;
    logic [LSIDE_W-1:0]    level_side;
  } obl_out_t;

endpackage

FILE: design/obl_if.sv
// Valid/ready channel interfaces for requests and results of the level table.
interface obl_in_if import obl_pkg::*; ();
  logic    valid;
  logic    ready;
  obl_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface obl_out_if import obl_pkg::*; ();
  logic     valid;
  logic     ready;
  obl_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/obl_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module obl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/order_book_level_table_unit.sv
// Top level of the order book level table: ask and bid quantity memories and best levels.
//
//   Channel  Modport            Payload    Carries
//   in_i     obl_in_if.sink     obl_in_t   one update or lookup request
//   out_o    obl_out_if.source  obl_out_t  one result per request
//
// A plain update passes through EXEC and RESULT and a lookup through EXEC, LOOKUP and
// RESULT before IDLE accepts the next request; the result register loads in RESULT.
// Deleting the best level walks the side's memory in steps of WALK_STEP levels, with
// one read (WALK_RD) and one check (WALK_CHK) for each visited level.
// After reset a clearing pass writes zero to every level, and no request is
// accepted until it ends.
// A result waits in the output register; the next request is accepted meanwhile,
// but its result is held until the register is free.
module order_book_level_table_unit import obl_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  obl_in_if.sink      in_i,
  obl_out_if.source   out_o
);

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_EXEC     = 7'b0000100,
    ST_LOOKUP   = 7'b0001000,
    ST_WALK_RD  = 7'b0010000,
    ST_WALK_CHK = 7'b0100000,
    ST_RESULT   = 7'b1000000
  } obl_state_e;

  obl_state_e          state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  obl_in_t             req_q, req_d;
  logic [BA_W-1:0]     best_ask_q, best_ask_d;
  logic [ADDR_W-1:0]   best_bid_q, best_bid_d;
  logic [QTY_BITS-1:0] ask_top_q, ask_top_d;
  logic [QTY_BITS-1:0] bid_top_q, bid_top_d;
  logic [QTY_BITS-1:0] lvl_qty_q, lvl_qty_d;
  logic [LSIDE_W-1:0]  lvl_side_q, lvl_side_d;
  obl_out_t            out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                in_ready;

  logic                ask_we, ask_re, bid_we, bid_re;
  logic [ADDR_W-1:0]   ask_waddr, ask_raddr, bid_waddr, bid_raddr;
  logic [QTY_BITS-1:0] ask_wdata, bid_wdata, ask_rdata, bid_rdata;

  logic [ADDR_W-1:0]   req_addr;
  logic [QTY_BITS-1:0] req_qty;
  logic                req_in_range;
  logic [BA_W-1:0]     ask_next;
  logic [ADDR_W-1:0]   bid_next;
  logic                ask_walk_end;

  assign req_addr     = ADDR_W'(req_q.tick_level);
  assign req_qty      = QTY_BITS'(req_q.quantity);
  assign req_in_range = 32'(req_q.tick_level) < NUM_LEVELS;
  assign ask_next     = best_ask_q + BA_W'(WALK_STEP);
  assign ask_walk_end = (32'(best_ask_q) + WALK_STEP) >= NUM_LEVELS;
  assign bid_next     = (32'(best_bid_q) < WALK_STEP) ? '0
                        : best_bid_q - ADDR_W'(WALK_STEP);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    req_d       = req_q;
    best_ask_d  = best_ask_q;
    best_bid_d  = best_bid_q;
    ask_top_d   = ask_top_q;
    bid_top_d   = bid_top_q;
    lvl_qty_d   = lvl_qty_q;
    lvl_side_d  = lvl_side_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    in_ready    = 1'b0;
    ask_we      = 1'b0;
    ask_waddr   = clr_cnt_q;
    ask_wdata   = '0;
    ask_re      = 1'b0;
    ask_raddr   = req_addr;
    bid_we      = 1'b0;
    bid_waddr   = clr_cnt_q;
    bid_wdata   = '0;
    bid_re      = 1'b0;
    bid_raddr   = req_addr;

    case (state_q)
      ST_CLEAR: begin
        ask_we    = 1'b1;
        bid_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (32'(clr_cnt_q) == NUM_LEVELS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          req_d   = in_i.payload;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        lvl_qty_d  = '0;
        lvl_side_d = LSIDE_NONE;
        state_d    = ST_RESULT;
        if (!req_in_range) begin
          state_d = ST_RESULT;
        end else if (req_q.kind == KIND_LOOKUP) begin
          ask_re  = 1'b1;
          bid_re  = 1'b1;
          state_d = ST_LOOKUP;
        end else if (req_q.side == SIDE_ASK) begin
          ask_we    = 1'b1;
          ask_waddr = req_addr;
          ask_wdata = req_qty;
          if (req_qty != '0) begin
            if ({1'b0, req_addr} < best_ask_q) begin
              best_ask_d = {1'b0, req_addr};
              ask_top_d  = req_qty;
            end else if ({1'b0, req_addr} == best_ask_q) begin
              ask_top_d = req_qty;
            end
          end else if ({1'b0, req_addr} == best_ask_q) begin
            state_d = ST_WALK_RD;
          end
        end else begin
          bid_we    = 1'b1;
          bid_waddr = req_addr;
          bid_wdata = req_qty;
          if (req_qty != '0) begin
            if (req_addr > best_bid_q) begin
              best_bid_d = req_addr;
              bid_top_d  = req_qty;
            end else if (req_addr == best_bid_q) begin
              bid_top_d = req_qty;
            end
          end else if (req_addr == best_bid_q) begin
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_LOOKUP: begin
        lvl_qty_d = (req_q.side == SIDE_BID) ? bid_rdata : ask_rdata;
        if (ask_rdata != '0) begin
          lvl_side_d = LSIDE_ASK;
        end else if (bid_rdata != '0) begin
          lvl_side_d = LSIDE_BID;
        end else begin
          lvl_side_d = LSIDE_NONE;
        end
        state_d = ST_RESULT;
      end
      ST_WALK_RD: begin
        if (req_q.side == SIDE_ASK) begin
          if (ask_walk_end) begin
            best_ask_d = BA_W'(NUM_LEVELS);
            ask_top_d  = '0;
            state_d    = ST_RESULT;
          end else begin
            best_ask_d = ask_next;
            ask_re     = 1'b1;
            ask_raddr  = ask_next[ADDR_W-1:0];
            state_d    = ST_WALK_CHK;
          end
        end else begin
          best_bid_d = bid_next;
          bid_re     = 1'b1;
          bid_raddr  = bid_next;
          state_d    = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (req_q.side == SIDE_ASK) begin
          if (ask_rdata != '0) begin
            ask_top_d = ask_rdata;
            state_d   = ST_RESULT;
          end else begin
            state_d = ST_WALK_RD;
          end
        end else begin
          bid_top_d = bid_rdata;
          if (bid_rdata != '0 || best_bid_q == '0) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d             = 1'b1;
          out_d.best_ask_level    = BEST_ASK_W'(best_ask_q);
          out_d.best_ask_quantity = QTY_W'(ask_top_q);
          out_d.best_bid_level    = LEVEL_W'(best_bid_q);
          out_d.best_bid_quantity = QTY_W'(bid_top_q);
          out_d.level_quantity    = QTY_W'(lvl_qty_q);
          out_d.level_side        = lvl_side_q;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      best_ask_q  <= BA_W'(NUM_LEVELS);
      best_bid_q  <= '0;
      ask_top_q   <= '0;
      bid_top_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      best_ask_q  <= best_ask_d;
      best_bid_q  <= best_bid_d;
      ask_top_q   <= ask_top_d;
      bid_top_q   <= bid_top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    lvl_qty_q  <= lvl_qty_d;
    lvl_side_q <= lvl_side_d;
    out_q      <= out_d;
  end

  obl_ram #(
    .WIDTH (QTY_BITS),
    .DEPTH (NUM_LEVELS)
  ) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (ask_we),
    .waddr_i (ask_waddr),
    .wdata_i (ask_wdata),
    .re_i    (ask_re),
    .raddr_i (ask_raddr),
    .rdata_o (ask_rdata)
  );

  obl_ram #(
    .WIDTH (QTY_BITS),
    .DEPTH (NUM_LEVELS)
  ) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (bid_we),
    .waddr_i (bid_waddr),
    .wdata_i (bid_wdata),
    .re_i    (bid_re),
    .raddr_i (bid_raddr),
    .rdata_o (bid_rdata)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // While idle, an empty ask side carries no cached quantity, and a held best ask always has one.
  a_ask_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && best_ask_q == BA_W'(NUM_LEVELS)) |-> ask_top_q == '0)
    else $error("cached best ask quantity is nonzero on an empty ask side");

  a_ask_held_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && best_ask_q != BA_W'(NUM_LEVELS)) |-> ask_top_q != '0)
    else $error("best ask level holds no quantity");

  a_ask_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(best_ask_q) <= NUM_LEVELS)
    else $error("best ask level beyond the empty sentinel");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ask_we || bid_we) |-> (state_q == ST_CLEAR || state_q == ST_EXEC))
    else $error("memory write outside clearing or execution");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result appeared without a finished request");

endmodule

FILE: test/obl_book_checker.sv
// Checker of the level table: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module obl_book_checker import obl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  obl_in_if    req_i,
  obl_out_if   res_i,
  output int   mismatch_count_o,
  output int   snapshots_pending_o
);

  bit [QTY_W-1:0] ask_book [NUM_LEVELS];
  bit [QTY_W-1:0] bid_book [NUM_LEVELS];
  int             best_ask_lvl;
  int             best_bid_lvl;
  obl_out_t       expected_snapshots [$];
  int             mismatch_total;
  int             results_seen;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    if (mismatch_total < 50) begin
      $display("ERROR: result %0d: %s is 0x%0h, expected 0x%0h",
               results_seen, what, seen, wanted);
    end
    mismatch_total++;
  endtask

  function automatic obl_out_t apply_book_request(input obl_in_t r);
    obl_out_t snap;
    int       lvl;
    bit       walking;
    snap = '0;
    lvl  = int'(r.tick_level);
    if (r.kind == KIND_UPDATE) begin
      if (r.side == SIDE_ASK) begin
        ask_book[lvl] = r.quantity;
        if (r.quantity != '0) begin
          if (lvl < best_ask_lvl) best_ask_lvl = lvl;
        end else if (lvl == best_ask_lvl) begin
          // The ask side walks up to the next level with quantity, or else lands on the empty sentinel at the top.
          walking = 1'b1;
          while (walking) begin
            if (best_ask_lvl >= NUM_LEVELS - WALK_STEP) begin
              best_ask_lvl = NUM_LEVELS;
              walking      = 1'b0;
            end else begin
              best_ask_lvl += WALK_STEP;
              walking      = (ask_book[best_ask_lvl] == '0);
            end
          end
        end
      end else begin
        bid_book[lvl] = r.quantity;
        if (r.quantity != '0) begin
          if (lvl > best_bid_lvl) best_bid_lvl = lvl;
        end else if (lvl == best_bid_lvl) begin
          // The bid side walks down and never goes below level zero.
          walking = 1'b1;
          while (walking) begin
            if (best_bid_lvl < WALK_STEP) begin
              best_bid_lvl = 0;
              walking      = 1'b0;
            end else begin
              best_bid_lvl -= WALK_STEP;
              walking      = (best_bid_lvl != 0) && (bid_book[best_bid_lvl] == '0);
            end
          end
        end
      end
    end else begin
      snap.level_quantity = (r.side == SIDE_ASK) ? ask_book[lvl] : bid_book[lvl];
      if (ask_book[lvl] != '0) snap.level_side = LSIDE_ASK;
      else if (bid_book[lvl] != '0) snap.level_side = LSIDE_BID;
      else snap.level_side = LSIDE_NONE;
    end
    snap.best_ask_level    = BEST_ASK_W'(best_ask_lvl);
    snap.best_ask_quantity = (best_ask_lvl < NUM_LEVELS) ? ask_book[best_ask_lvl] : '0;
    snap.best_bid_level    = LEVEL_W'(best_bid_lvl);
    snap.best_bid_quantity = bid_book[best_bid_lvl];
    return snap;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    obl_out_t want;
    obl_out_t got;
    if (!rst_ni) begin
      foreach (ask_book[i]) begin
        ask_book[i] = '0;
        bid_book[i] = '0;
      end
      best_ask_lvl = NUM_LEVELS;
      best_bid_lvl = 0;
      expected_snapshots.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = res_i.payload;
        results_seen++;
        if (expected_snapshots.size() == 0) begin
          report_mismatch("result with nothing expected, best ask level",
                          64'(got.best_ask_level), 64'(0));
        end else begin
          want = expected_snapshots.pop_front();
          if (got.best_ask_level !== want.best_ask_level)
            report_mismatch("best_ask_level", 64'(got.best_ask_level),
                            64'(want.best_ask_level));
          if (got.best_ask_quantity !== want.best_ask_quantity)
            report_mismatch("best_ask_quantity", 64'(got.best_ask_quantity),
                            64'(want.best_ask_quantity));
          if (got.best_bid_level !== want.best_bid_level)
            report_mismatch("best_bid_level", 64'(got.best_bid_level),
                            64'(want.best_bid_level));
          if (got.best_bid_quantity !== want.best_bid_quantity)
            report_mismatch("best_bid_quantity", 64'(got.best_bid_quantity),
                            64'(want.best_bid_quantity));
          if (got.level_quantity !== want.level_quantity)
            report_mismatch("level_quantity", 64'(got.level_quantity),
                            64'(want.level_quantity));
          if (got.level_side !== want.level_side)
            report_mismatch("level_side", 64'(got.level_side), 64'(want.level_side));
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_snapshots.push_back(apply_book_request(req_i.payload));
      end
      snapshots_pending_o <= expected_snapshots.size();
      mismatch_count_o    <= mismatch_total;
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the level table testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import obl_pkg::*;

  localparam int IDLE_NONE   = 0;
  localparam int IDLE_LIGHT  = 1;
  localparam int IDLE_HEAVY  = 2;
  localparam int BOOK_WINDOW = 24;
  localparam int EPISODES    = 16;
  localparam int EPISODE_LEN = 118;
  localparam int LONG_HOLD   = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatches;
  int   snapshots_pending;
  int   tx_mode;
  int   rx_mode;
  bit   long_hold_req;
  int   long_holds_done;
  int   n_updates;
  int   n_lookups;
  int   level_base [EPISODES];

  obl_in_if  req_ch ();
  obl_out_if res_ch ();

  order_book_level_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  obl_book_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_i               (req_ch),
    .res_i               (res_ch),
    .mismatch_count_o    (mismatches),
    .snapshots_pending_o (snapshots_pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_idle(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT) begin
      if (r < 70) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
    end
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [QTY_W-1:0] pick_quantity();
    logic [63:0]      wide;
    logic [QTY_W-1:0] q;
    int               r;
    r    = $urandom_range(0, 99);
    wide = {$urandom(), $urandom()};
    if (r < 10) q = '1;
    else if (r < 20) q = QTY_W'($urandom_range(1, 255));
    else if (r < 30) q = QTY_W'(1) << $urandom_range(0, QTY_W - 1);
    else q = wide[QTY_W-1:0];
    if (q == '0) q = QTY_W'(1);
    return q;
  endfunction

  task automatic send_request(input logic kind, input logic side,
                              input int level, input logic [QTY_W-1:0] qty);
    obl_in_t req;
    int      gap;
    req.kind        = kind;
    req.side        = side;
    req.tick_level  = LEVEL_W'(level);
    req.quantity    = qty;
    gap = pick_idle(tx_mode);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.payload = req;
    req_ch.valid   = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (kind == KIND_UPDATE) n_updates++;
    else n_lookups++;
  endtask

  initial begin
    int stall_left;
    res_ch.ready    = 1'b0;
    long_holds_done = 0;
    stall_left      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready  = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk_i);
        long_holds_done++;
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        stall_left   = pick_idle(rx_mode);
      end
    end
  end

  initial begin
    int               ask_base;
    int               bid_base;
    int               r;
    int               lvl;
    int               drain;
    logic             side;
    logic [QTY_W-1:0] qty;

    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    tx_mode        = IDLE_NONE;
    rx_mode        = IDLE_NONE;
    long_hold_req  = 1'b0;
    n_updates      = 0;
    n_lookups      = 0;
    for (int j = 0; j < EPISODES; j++) begin
      level_base[j] = 3000 + j * 3800 + $urandom_range(0, 1000);
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty book, both ends of the level range, crossed sides,
    // walks to the sentinel and to level zero, and zeros at level zero.
    send_request(KIND_LOOKUP, SIDE_ASK, 0, '0);
    send_request(KIND_UPDATE, SIDE_BID, 0, '0);
    send_request(KIND_UPDATE, SIDE_ASK, 0, '0);
    send_request(KIND_UPDATE, SIDE_BID, 0, QTY_W'(7));
    send_request(KIND_LOOKUP, SIDE_BID, 0, '1);
    send_request(KIND_UPDATE, SIDE_ASK, 65535, '1);
    send_request(KIND_UPDATE, SIDE_BID, 65535, QTY_W'(1));
    send_request(KIND_LOOKUP, SIDE_ASK, 65535, '0);
    send_request(KIND_LOOKUP, SIDE_BID, 65535, '0);
    send_request(KIND_UPDATE, SIDE_ASK, 65535, '0);
    send_request(KIND_LOOKUP, SIDE_BID, 65535, '0);
    send_request(KIND_UPDATE, SIDE_BID, 65534, QTY_W'(1) << (QTY_W - 1));
    send_request(KIND_UPDATE, SIDE_BID, 65535, '0);
    send_request(KIND_UPDATE, SIDE_BID, 65534, '0);
    send_request(KIND_UPDATE, SIDE_BID, 0, '0);
    send_request(KIND_UPDATE, SIDE_ASK, 65530, QTY_W'(32'h0001_0000));
    send_request(KIND_UPDATE, SIDE_ASK, 65531, QTY_W'(5));
    send_request(KIND_UPDATE, SIDE_ASK, 65533, QTY_W'(3));
    send_request(KIND_UPDATE, SIDE_ASK, 65530, '0);
    send_request(KIND_UPDATE, SIDE_ASK, 65531, '0);
    send_request(KIND_LOOKUP, SIDE_ASK, 65533, '0);
    send_request(KIND_UPDATE, SIDE_ASK, 65533, '0);
    send_request(KIND_LOOKUP, SIDE_ASK, 65533, '0);

    // Asks move down and bids move up through price windows, each window
    // backed by a guard level that bounds the walks.
    for (int ep = 0; ep < EPISODES; ep++) begin
      ask_base = level_base[EPISODES - 1 - ep];
      bid_base = level_base[ep];
      tx_mode  = ep % 3;
      rx_mode  = (ep / 3) % 3;
      if (ep == 5 || ep == 11) long_hold_req = 1'b1;
      send_request(KIND_UPDATE, SIDE_ASK, ask_base + BOOK_WINDOW + 2, pick_quantity());
      send_request(KIND_UPDATE, SIDE_BID, bid_base - 2, pick_quantity());
      repeat (EPISODE_LEN) begin
        r   = $urandom_range(0, 99);
        qty = ($urandom_range(0, 99) < 40) ? '0 : pick_quantity();
        if (r < 38) begin
          send_request(KIND_UPDATE, SIDE_ASK,
                       ask_base + $urandom_range(0, BOOK_WINDOW - 1), qty);
        end else if (r < 76) begin
          send_request(KIND_UPDATE, SIDE_BID,
                       bid_base + $urandom_range(0, BOOK_WINDOW - 1), qty);
        end else if (r < 94) begin
          side = $urandom_range(0, 1) ? SIDE_BID : SIDE_ASK;
          case ($urandom_range(0, 3))
            0: lvl = ask_base + $urandom_range(0, BOOK_WINDOW + 2);
            1: lvl = bid_base - 2 + $urandom_range(0, BOOK_WINDOW + 1);
            2: lvl = $urandom_range(0, 65535);
            default: begin
              lvl = level_base[$urandom_range(0, EPISODES - 1)] +
                    $urandom_range(0, BOOK_WINDOW - 1);
            end
          endcase
          send_request(KIND_LOOKUP, side, lvl, pick_quantity());
        end else begin
          side = $urandom_range(0, 1) ? SIDE_BID : SIDE_ASK;
          send_request(KIND_UPDATE, side, $urandom_range(0, 65535), '0);
        end
      end
    end
    req_ch.valid = 1'b0;

    drain = 0;
    while (snapshots_pending != 0 && drain < 50000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d updates and %0d lookups over %0d price windows per side.",
             n_updates, n_lookups, EPISODES);
    $display("Results were stalled at random, with %0d hold-offs of %0d cycles.",
             long_holds_done, LONG_HOLD);
    if (snapshots_pending != 0) begin
      $display("ERROR: %0d results never arrived", snapshots_pending);
    end
    if (mismatches == 0 && snapshots_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/obl_pkg.sv
design/obl_if.sv
design/obl_ram.sv
design/order_book_level_table_unit.sv
test/obl_book_checker.sv
test/testbench.sv
